// ===== rtl/core/nssd_pkg.sv =====
// ----------------------------------------------------------------------------
// nssd_pkg
// Shared types and constants for the nearest sphere surface distance core.
// ----------------------------------------------------------------------------
package nssd_pkg;

  localparam int MaxSpheres = 1024;
  localparam int AddrW      = $clog2(MaxSpheres);
  localparam int CountW     = $clog2(MaxSpheres + 1);
  localparam int CoordW     = 24;
  localparam int RadW       = 23;
  localparam int DiffW      = CoordW + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int SumW       = SqW + 2;
  localparam int RootW      = SumW / 2;
  localparam int DistW      = 26;
  localparam int FuncW      = 2;

  localparam logic [FuncW-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FuncW-1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load_point;
    logic             write_entry;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             first;
    logic             take_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } status_t;

endpackage

// ===== rtl/core/nssd_if.sv =====
// ----------------------------------------------------------------------------
// nssd_in_if / nssd_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface nssd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [nssd_pkg::FuncW-1:0]           func;
  logic signed [nssd_pkg::CoordW-1:0]   pos_x;
  logic signed [nssd_pkg::CoordW-1:0]   pos_y;
  logic signed [nssd_pkg::CoordW-1:0]   pos_z;
  logic [nssd_pkg::RadW-1:0]            sphere_radius_in;
  modport source (output valid, func, pos_x, pos_y, pos_z, sphere_radius_in, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, sphere_radius_in, output ready);
endinterface

interface nssd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [nssd_pkg::DistW-1:0]  min_distance;
  logic                               table_empty;
  modport source (output valid, min_distance, table_empty, input ready);
  modport sink (input valid, min_distance, table_empty, output ready);
endinterface

// ===== rtl/core/nssd_datapath.sv =====
// ----------------------------------------------------------------------------
// nssd_datapath
// Sphere table memories, squared-distance pipeline, shared iterative square
// root and running minimum.
// ----------------------------------------------------------------------------
module nssd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  nssd_pkg::cmd_t                     cmd,
  output nssd_pkg::status_t                  status,
  input  logic [nssd_pkg::AddrW-1:0]         wr_addr,
  input  logic signed [nssd_pkg::CoordW-1:0] in_x,
  input  logic signed [nssd_pkg::CoordW-1:0] in_y,
  input  logic signed [nssd_pkg::CoordW-1:0] in_z,
  input  logic [nssd_pkg::RadW-1:0]          in_rad,
  input  logic [nssd_pkg::RadW-1:0]          probe_radius,
  output logic signed [nssd_pkg::DistW-1:0]  best
);

  localparam int SumW  = nssd_pkg::SumW;
  localparam int RootW = nssd_pkg::RootW;
  localparam int DiffW = nssd_pkg::DiffW;
  localparam int SqW   = nssd_pkg::SqW;

  // sphere table
  logic signed [nssd_pkg::CoordW-1:0] mem_x [nssd_pkg::MaxSpheres];
  logic signed [nssd_pkg::CoordW-1:0] mem_y [nssd_pkg::MaxSpheres];
  logic signed [nssd_pkg::CoordW-1:0] mem_z [nssd_pkg::MaxSpheres];
  logic [nssd_pkg::RadW-1:0]          mem_r [nssd_pkg::MaxSpheres];
  logic signed [nssd_pkg::CoordW-1:0] rd_x, rd_y, rd_z;
  logic [nssd_pkg::RadW-1:0]          rd_r;

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem_x[wr_addr] <= in_x;
      mem_y[wr_addr] <= in_y;
      mem_z[wr_addr] <= in_z;
      mem_r[wr_addr] <= in_rad;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[cmd.rd_addr];
      rd_y <= mem_y[cmd.rd_addr];
      rd_z <= mem_z[cmd.rd_addr];
      rd_r <= mem_r[cmd.rd_addr];
    end
  end

  // query point
  logic signed [nssd_pkg::CoordW-1:0] pt_x, pt_y, pt_z;
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      pt_x <= in_x;
      pt_y <= in_y;
      pt_z <= in_z;
    end
  end

  // stage valids: read, diff, square
  logic              v_rd, v_df, v_sq;
  logic              f_rd, f_df, f_sq;
  logic [DiffW-1:0]  dx, dy, dz;
  logic [nssd_pkg::RadW-1:0] r_df, r_sq;
  logic [SqW-1:0]    sx, sy, sz;

  function automatic logic [DiffW-1:0] absdiff(input logic signed [nssd_pkg::CoordW-1:0] a,
                                                input logic signed [nssd_pkg::CoordW-1:0] b);
    logic signed [DiffW-1:0] d;
    d = DiffW'(a) - DiffW'(b);
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

  // advance difference and square stages
  always_ff @(posedge clk) begin
    dx   <= absdiff(rd_x, pt_x);
    dy   <= absdiff(rd_y, pt_y);
    dz   <= absdiff(rd_z, pt_z);
    r_df <= rd_r;
    f_df <= f_rd;
    sx   <= dx * dx;
    sy   <= dy * dy;
    sz   <= dz * dz;
    r_sq <= r_df;
    f_sq <= f_df;
  end

  // square root unit: one result bit per cycle
  localparam int StepW = $clog2(RootW + 1);
  logic [SumW-1:0]   rem;
  logic [RootW-1:0]  root;
  logic [SumW-1:0]   rad_acc;
  logic [StepW-1:0]  step;
  logic              sq_busy;
  logic              sq_first;
  logic [nssd_pkg::RadW-1:0] sq_rad;
  logic [SumW+1:0]   trial;
  logic [SumW+1:0]   rem_sh;

  assign rem_sh = {rem, rad_acc[SumW-1 -: 2]};
  assign trial  = rem_sh - {root, 2'b01};

  logic signed [nssd_pkg::DistW-1:0] surf_dist;
  assign surf_dist = nssd_pkg::DistW'(root) - nssd_pkg::DistW'(sq_rad) -
                     nssd_pkg::DistW'(probe_radius);

  logic sq_done;
  assign sq_done = sq_busy && (step == StepW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd    <= 1'b0;
      v_df    <= 1'b0;
      v_sq    <= 1'b0;
      sq_busy <= 1'b0;
    end else begin
      v_rd <= cmd.rd_en;
      v_df <= v_rd;
      v_sq <= v_df;
      if (v_sq) begin
        sq_busy <= 1'b1;
      end else if (sq_done) begin
        sq_busy <= 1'b0;
      end
    end
    f_rd <= cmd.first;
    if (v_sq) begin
      rem      <= '0;
      root     <= '0;
      rad_acc  <= SumW'(sx) + SumW'(sy) + SumW'(sz);
      step     <= StepW'(RootW);
      sq_rad   <= r_sq;
      sq_first <= f_sq;
    end else if (sq_busy && step != StepW'(0)) begin
      if (!trial[SumW+1]) begin
        rem  <= SumW'(trial);
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= SumW'(rem_sh);
        root <= {root[RootW-2:0], 1'b0};
      end
      rad_acc <= {rad_acc[SumW-3:0], 2'b00};
      step    <= step - StepW'(1);
    end
  end

  // hold running minimum
  always_ff @(posedge clk) begin
    if (cmd.take_result) begin
      best <= '0;
    end else if (sq_done && (sq_first || surf_dist < best)) begin
      best <= surf_dist;
    end
  end

  assign status.busy = v_rd | v_df | v_sq | sq_busy;

endmodule

// ===== rtl/core/nssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nssd_ctrl
// Controller: takes items, counts the table, issues one sphere at a time to
// the datapath and presents the result.
// ----------------------------------------------------------------------------
module nssd_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nssd_pkg::FuncW-1:0]     func,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           table_empty,
  output logic [nssd_pkg::AddrW-1:0]     wr_addr,
  output nssd_pkg::cmd_t                 cmd,
  input  nssd_pkg::status_t              status
);

  nssd_pkg::state_t state, state_next;
  logic [nssd_pkg::CountW-1:0] count, count_next;
  logic [nssd_pkg::CountW-1:0] idx, idx_next;
  logic empty_next;
  logic accept;

  assign accept  = in_valid && in_ready;
  assign wr_addr = count[nssd_pkg::AddrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nssd_pkg::ST_IDLE;
      count       <= '0;
      idx         <= '0;
      table_empty <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      idx         <= idx_next;
      table_empty <= empty_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    empty_next       = table_empty;
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    cmd.load_point   = 1'b0;
    cmd.write_entry  = 1'b0;
    cmd.rd_en        = 1'b0;
    cmd.rd_addr      = idx[nssd_pkg::AddrW-1:0];
    cmd.first        = (idx == '0);
    cmd.take_result  = 1'b0;
    unique case (state)
      nssd_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_point = accept;
        if (accept) begin
          priority if (func == nssd_pkg::FUNC_CLEAR) begin
            count_next = '0;
          end else if (func == nssd_pkg::FUNC_APPEND) begin
            if (count < nssd_pkg::CountW'(nssd_pkg::MaxSpheres)) begin
              cmd.write_entry = 1'b1;
              count_next      = count + nssd_pkg::CountW'(1);
            end
          end else if (func == nssd_pkg::FUNC_QUERY) begin
            idx_next = '0;
            if (count == '0) begin
              empty_next      = 1'b1;
              cmd.take_result = 1'b1;
              state_next      = nssd_pkg::ST_OUT;
            end else begin
              empty_next = 1'b0;
              state_next = nssd_pkg::ST_SCAN;
            end
          end else begin
            // drop the unused code
            count_next = count;
          end
        end
      end
      // issue one sphere, then wait for its root
      nssd_pkg::ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        idx_next   = idx + nssd_pkg::CountW'(1);
        state_next = nssd_pkg::ST_ROOT;
      end
      nssd_pkg::ST_ROOT: begin
        if (!status.busy) begin
          state_next = (idx == count) ? nssd_pkg::ST_DRAIN : nssd_pkg::ST_SCAN;
        end
      end
      nssd_pkg::ST_DRAIN: begin
        state_next = nssd_pkg::ST_OUT;
      end
      nssd_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = nssd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nssd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/nearest_sphere_surface_distance_core.sv =====
// ----------------------------------------------------------------------------
// nearest_sphere_surface_distance_core
// Least surface distance from a query point to a table of up to 1024 spheres.
// ----------------------------------------------------------------------------
// Each sphere of a query goes through read, difference and square stages and
// then a 26-step bit-serial square root, one sphere at a time. The result
// holds until taken. Reset (rst, synchronous) empties the table and clears
// probe_radius; the table memories are not cleared.
module nearest_sphere_surface_distance_core (
  input  logic                          clk,
  input  logic                          rst,
  nssd_in_if.sink                       in_ch,
  nssd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [nssd_pkg::RadW-1:0]     cfg_wdata
);

  nssd_pkg::cmd_t    cmd;
  nssd_pkg::status_t status;
  logic [nssd_pkg::AddrW-1:0] wr_addr;
  logic [nssd_pkg::RadW-1:0]  probe_radius;
  logic signed [nssd_pkg::DistW-1:0] best;

  // hold probe radius
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_radius <= '0;
    end else if (cfg_we) begin
      probe_radius <= cfg_wdata;
    end
  end

  nssd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .func        (in_ch.func),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .table_empty (out_ch.table_empty),
    .wr_addr     (wr_addr),
    .cmd         (cmd),
    .status      (status)
  );

  nssd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .wr_addr      (wr_addr),
    .in_x         (in_ch.pos_x),
    .in_y         (in_ch.pos_y),
    .in_z         (in_ch.pos_z),
    .in_rad       (in_ch.sphere_radius_in),
    .probe_radius (probe_radius),
    .best         (best)
  );

  assign out_ch.min_distance = best;

endmodule

// ===== rtl/core/nssd_checker.sv =====
// ----------------------------------------------------------------------------
// nssd_checker
// Port-level checks for the core, bound to the top level.
// ----------------------------------------------------------------------------
module nssd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               table_empty,
  input logic signed [nssd_pkg::DistW-1:0]  min_distance
);

  // no new item while a result is shown
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // empty table gives zero distance
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_empty) |-> (min_distance == '0))
    else $error("empty result with nonzero distance");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(min_distance)))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");

endmodule

bind nearest_sphere_surface_distance_core nssd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .table_empty  (out_ch.table_empty),
  .min_distance (out_ch.min_distance)
);
